// ===== design/sipu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sipu_pkg: shared types and widths for the segment intersection point unit
// Coordinate width, internal arithmetic widths and the transfer structs.
// ----------------------------------------------------------------------------
package sipu_pkg;

    // Coordinate width (Q12.4 at 16 bits)
    localparam int COORD_W = 16;
    // Endpoint differences
    localparam int DIFF_W  = COORD_W + 1;
    // Edge cross products
    localparam int PROD_W  = 2 * DIFF_W;
    // Line function values
    localparam int SIDE_W  = PROD_W + 1;
    // Denominator v0 - v1, signed and magnitude
    localparam int DEN_W   = SIDE_W + 1;
    // Numerator products and difference
    localparam int NPROD_W = SIDE_W + COORD_W;
    localparam int NUM_W   = NPROD_W + 1;

    typedef struct packed {
        logic [COORD_W-1:0] first_start_x;
        logic [COORD_W-1:0] first_start_y;
        logic [COORD_W-1:0] first_end_x;
        logic [COORD_W-1:0] first_end_y;
        logic [COORD_W-1:0] second_start_x;
        logic [COORD_W-1:0] second_start_y;
        logic [COORD_W-1:0] second_end_x;
        logic [COORD_W-1:0] second_end_y;
    } t_seg_item;

    typedef struct packed {
        logic               crossing;
        logic [COORD_W-1:0] cross_x;
        logic [COORD_W-1:0] cross_y;
    } t_cross_item;

    // State handed from one divider cell to the next
    typedef struct packed {
        logic               valid;
        logic               hit;
        logic               neg_x;
        logic               neg_y;
        logic [DEN_W-1:0]   den;
        logic [NUM_W-1:0]   rem_x;
        logic [NUM_W-1:0]   rem_y;
        logic [COORD_W-1:0] quo_x;
        logic [COORD_W-1:0] quo_y;
    } t_div_stage;

endpackage

// ===== design/sipu_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sipu_div_cell: one restoring division cell
// Settles quotient bit SHIFT for both coordinates and passes the rest on.
// ----------------------------------------------------------------------------
module sipu_div_cell #(
    parameter int SHIFT = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sipu_pkg::t_div_stage  i_stage,
    output sipu_pkg::t_div_stage  o_stage
);

    logic [sipu_pkg::NUM_W-1:0] den_sh;
    sipu_pkg::t_div_stage       n_stage;
    sipu_pkg::t_div_stage       r_stage;

    // Trial subtract of the shifted divisor
    always_comb begin
        den_sh  = sipu_pkg::NUM_W'(i_stage.den) << SHIFT;
        n_stage = i_stage;
        if (i_stage.rem_x >= den_sh) begin
            n_stage.rem_x        = i_stage.rem_x - den_sh;
            n_stage.quo_x[SHIFT] = 1'b1;
        end
        if (i_stage.rem_y >= den_sh) begin
            n_stage.rem_y        = i_stage.rem_y - den_sh;
            n_stage.quo_y[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stage <= n_stage;
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end
    end

    assign o_stage = r_stage;

endmodule

// ===== design/segment_intersection_point_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection_point_unit: proper crossing test of two segments
// Line-side tests and crossing point with a chain of division cells.
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_item with two segments and pulse i_start. o_busy is always low,
//   so a transfer is taken in every cycle that i_start is high.
//   Each item gives one result: o_strobe is high for one cycle with
//   o_result holding crossing, cross_x and cross_y. Non-crossing,
//   touching and collinear pairs give crossing = 0 and zero coordinates.
//   Pipeline: 5 front stages (differences, products, line values,
//   denominator and numerator products, magnitudes), then one division cell
//   per quotient bit (COORD_W cells), then one output stage.
//   Throughput: one item per cycle; every stage and every cell of the
//   divider chain registers its data each cycle.
//   Reset clears the valid bits of all stages; items in flight are dropped.
//   The receiver cannot stall, so no backpressure exists inside.
// ----------------------------------------------------------------------------
module segment_intersection_point_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    output logic                   o_busy,
    input  sipu_pkg::t_seg_item    i_item,
    output logic                   o_strobe,
    output sipu_pkg::t_cross_item  o_result
);

    localparam int W  = sipu_pkg::COORD_W;
    localparam int DW = sipu_pkg::DIFF_W;
    localparam int PW = sipu_pkg::PROD_W;
    localparam int SW = sipu_pkg::SIDE_W;
    localparam int EW = sipu_pkg::DEN_W;
    localparam int MW = sipu_pkg::NPROD_W;
    localparam int NW = sipu_pkg::NUM_W;

    logic accept;
    assign accept = i_start && !o_busy;
    assign o_busy = 1'b0;

    // Stage 1: endpoint differences
    logic signed [W-1:0]  ax, ay, bx, by, px, py, qx, qy;
    logic                 r_v1;
    logic signed [DW-1:0] r_e1x, r_e1y, r_e2x, r_e2y;
    logic signed [DW-1:0] r_pax, r_pay, r_qax, r_qay, r_bpx, r_bpy;
    logic signed [W-1:0]  r1_px, r1_py, r1_qx, r1_qy;

    assign ax = i_item.first_start_x;
    assign ay = i_item.first_start_y;
    assign bx = i_item.first_end_x;
    assign by = i_item.first_end_y;
    assign px = i_item.second_start_x;
    assign py = i_item.second_start_y;
    assign qx = i_item.second_end_x;
    assign qy = i_item.second_end_y;

    always_ff @(posedge i_clk) begin
        r_e1x <= DW'(bx) - DW'(ax);
        r_e1y <= DW'(by) - DW'(ay);
        r_e2x <= DW'(qx) - DW'(px);
        r_e2y <= DW'(qy) - DW'(py);
        r_pax <= DW'(px) - DW'(ax);
        r_pay <= DW'(py) - DW'(ay);
        r_qax <= DW'(qx) - DW'(ax);
        r_qay <= DW'(qy) - DW'(ay);
        r_bpx <= DW'(bx) - DW'(px);
        r_bpy <= DW'(by) - DW'(py);
        r1_px <= px;
        r1_py <= py;
        r1_qx <= qx;
        r1_qy <= qy;
        r_v1  <= accept;
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end
    end

    // Stage 2: edge products
    logic                 r_v2;
    logic signed [PW-1:0] r_v0a, r_v0b, r_v1a, r_v1b, r_u0a, r_u0b, r_u1a, r_u1b;
    logic signed [W-1:0]  r2_px, r2_py, r2_qx, r2_qy;
    logic signed [DW-1:0] neg_pax, neg_pay;

    assign neg_pax = -r_pax;
    assign neg_pay = -r_pay;

    always_ff @(posedge i_clk) begin
        r_v0a <= PW'(r_e1y) * PW'(r_pax);
        r_v0b <= PW'(r_e1x) * PW'(r_pay);
        r_v1a <= PW'(r_e1y) * PW'(r_qax);
        r_v1b <= PW'(r_e1x) * PW'(r_qay);
        r_u0a <= PW'(r_e2y) * PW'(neg_pax);
        r_u0b <= PW'(r_e2x) * PW'(neg_pay);
        r_u1a <= PW'(r_e2y) * PW'(r_bpx);
        r_u1b <= PW'(r_e2x) * PW'(r_bpy);
        r2_px <= r1_px;
        r2_py <= r1_py;
        r2_qx <= r1_qx;
        r2_qy <= r1_qy;
        r_v2  <= r_v1;
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end
    end

    // Stage 3: line function values
    logic                 r_v3;
    logic signed [SW-1:0] r_s0, r_s1, r_t0, r_t1;
    logic signed [W-1:0]  r3_px, r3_py, r3_qx, r3_qy;

    always_ff @(posedge i_clk) begin
        r_s0  <= SW'(r_v0a) - SW'(r_v0b);
        r_s1  <= SW'(r_v1a) - SW'(r_v1b);
        r_t0  <= SW'(r_u0a) - SW'(r_u0b);
        r_t1  <= SW'(r_u1a) - SW'(r_u1b);
        r3_px <= r2_px;
        r3_py <= r2_py;
        r3_qx <= r2_qx;
        r3_qy <= r2_qy;
        r_v3  <= r_v2;
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end
    end

    // Stage 4: strict opposite-side test, denominator, numerator products
    logic                 s0_n, s0_p, s1_n, s1_p, t0_n, t0_p, t1_n, t1_p;
    logic                 r_v4, r_hit4;
    logic signed [EW-1:0] r_den;
    logic signed [MW-1:0] r_nxa, r_nxb, r_nya, r_nyb;

    assign s0_n = r_s0[SW-1];
    assign s0_p = !r_s0[SW-1] && (|r_s0);
    assign s1_n = r_s1[SW-1];
    assign s1_p = !r_s1[SW-1] && (|r_s1);
    assign t0_n = r_t0[SW-1];
    assign t0_p = !r_t0[SW-1] && (|r_t0);
    assign t1_n = r_t1[SW-1];
    assign t1_p = !r_t1[SW-1] && (|r_t1);

    always_ff @(posedge i_clk) begin
        r_hit4 <= ((s0_n && s1_p) || (s0_p && s1_n)) &&
                  ((t0_n && t1_p) || (t0_p && t1_n));
        r_den  <= EW'(r_s0) - EW'(r_s1);
        r_nxa  <= MW'(r_s0) * MW'(r3_qx);
        r_nxb  <= MW'(r_s1) * MW'(r3_px);
        r_nya  <= MW'(r_s0) * MW'(r3_qy);
        r_nyb  <= MW'(r_s1) * MW'(r3_py);
        r_v4   <= r_v3;
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end
    end

    // Stage 5: numerators, magnitudes and quotient signs
    logic signed [NW-1:0] nx, ny;
    logic [EW-1:0]        den_mag;
    sipu_pkg::t_div_stage n_head;
    sipu_pkg::t_div_stage r_head;

    always_comb begin
        nx             = NW'(r_nxa) - NW'(r_nxb);
        ny             = NW'(r_nya) - NW'(r_nyb);
        den_mag        = r_den[EW-1] ? -r_den : r_den;
        n_head.valid   = r_v4;
        n_head.hit     = r_hit4;
        n_head.neg_x   = nx[NW-1] ^ r_den[EW-1];
        n_head.neg_y   = ny[NW-1] ^ r_den[EW-1];
        n_head.den     = den_mag;
        n_head.rem_x   = nx[NW-1] ? -nx : nx;
        n_head.rem_y   = ny[NW-1] ? -ny : ny;
        n_head.quo_x   = '0;
        n_head.quo_y   = '0;
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        if (!i_rst_n) begin
            r_head.valid <= 1'b0;
        end
    end

    // Division cells, most significant quotient bit first
    sipu_pkg::t_div_stage chain [W+1];

    assign chain[0] = r_head;

    for (genvar g = 0; g < W; g++) begin : g_cell
        sipu_div_cell #(
            .SHIFT (W - 1 - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (chain[g]),
            .o_stage (chain[g+1])
        );
    end

    // Output stage: apply sign, zero when no crossing
    sipu_pkg::t_div_stage  tail;
    sipu_pkg::t_cross_item n_result;
    sipu_pkg::t_cross_item r_result;
    logic                  r_strobe;

    assign tail = chain[W];

    always_comb begin
        n_result.crossing = tail.hit;
        n_result.cross_x  = '0;
        n_result.cross_y  = '0;
        if (tail.hit) begin
            n_result.cross_x = tail.neg_x ? -tail.quo_x : tail.quo_x;
            n_result.cross_y = tail.neg_y ? -tail.quo_y : tail.quo_y;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        r_strobe <= tail.valid;
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ===== verif/tb_segment_intersection_point_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_intersection_point_unit: self-checking bench for the unit
// Drives segment pairs through the start/busy handshake, predicts crossing
// flag and point per pair, and compares each strobed result in order.
// ----------------------------------------------------------------------------
module tb_segment_intersection_point_unit;

    localparam int COORD_W   = sipu_pkg::COORD_W;
    localparam int LATENCY   = COORD_W + 6;
    localparam int MAX_CYCLE = 200000;

    typedef sipu_pkg::t_seg_item   t_seg_item;
    typedef sipu_pkg::t_cross_item t_cross_item;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    t_seg_item   i_item;
    logic        o_strobe;
    t_cross_item o_result;

    t_cross_item crossings_due[$];
    int          idle_pct;
    int          cycle_cnt;
    bit          failed;

    segment_intersection_point_unit DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .o_busy   (o_busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // Clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Line through a-b evaluated at p
    function automatic longint line_side(longint ax, longint ay, longint bx,
                                         longint by, longint px, longint py);
        return (by - ay) * (px - ax) + (ax - bx) * (py - ay);
    endfunction

    function automatic int sgn(longint v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    // Expected crossing for one pair; values fit in 64 bits at 16-bit coords
    function automatic t_cross_item predict_crossing(t_seg_item it);
        t_cross_item r;
        longint ax, ay, bx, by, px, py, qx, qy, v0, v1, u0, u1, den;
        longint nx, ny;
        ax = longint'($signed(it.first_start_x));
        ay = longint'($signed(it.first_start_y));
        bx = longint'($signed(it.first_end_x));
        by = longint'($signed(it.first_end_y));
        px = longint'($signed(it.second_start_x));
        py = longint'($signed(it.second_start_y));
        qx = longint'($signed(it.second_end_x));
        qy = longint'($signed(it.second_end_y));
        v0 = line_side(ax, ay, bx, by, px, py);
        v1 = line_side(ax, ay, bx, by, qx, qy);
        u0 = line_side(px, py, qx, qy, ax, ay);
        u1 = line_side(px, py, qx, qy, bx, by);
        r = '0;
        if (sgn(v0) * sgn(v1) < 0 && sgn(u0) * sgn(u1) < 0) begin
            // Rewritten as P0 + v0*(P1-P0)/(v0-v1) would change rounding;
            // keep the exact form, the products stay under 2^63
            den = v0 - v1;
            nx  = v0 * qx - v1 * px;
            ny  = v0 * qy - v1 * py;
            r.crossing = 1'b1;
            r.cross_x  = COORD_W'(nx / den);
            r.cross_y  = COORD_W'(ny / den);
        end
        return r;
    endfunction

    // Send one pair; holds start across back-to-back transfers
    task automatic send_pair(t_seg_item it);
        while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        crossings_due.push_back(predict_crossing(it));
    endtask

    task automatic drain();
        i_start <= 1'b0;
        while (crossings_due.size() > 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(3, 0))
            0:       return COORD_W'($urandom);
            1:       return COORD_W'($signed($urandom_range(200, 0)) - 100);
            2:       return COORD_W'($urandom_range(1, 0) ? 16'h7fff : 16'h8000);
            default: return COORD_W'($signed($urandom_range(4000, 0)) - 2000);
        endcase
    endfunction

    function automatic t_seg_item rand_pair();
        t_seg_item it;
        it.first_start_x  = rand_coord();
        it.first_start_y  = rand_coord();
        it.first_end_x    = rand_coord();
        it.first_end_y    = rand_coord();
        it.second_start_x = rand_coord();
        it.second_start_y = rand_coord();
        it.second_end_x   = rand_coord();
        it.second_end_y   = rand_coord();
        return it;
    endfunction

    // Pair built around a common point so that most cross
    function automatic t_seg_item crossing_pair();
        t_seg_item it;
        int cx, cy, dx0, dy0, dx1, dy1;
        cx  = $signed($urandom_range(30000, 0)) - 15000;
        cy  = $signed($urandom_range(30000, 0)) - 15000;
        dx0 = $signed($urandom_range(30000, 0)) - 15000;
        dy0 = $signed($urandom_range(30000, 0)) - 15000;
        dx1 = $signed($urandom_range(30000, 0)) - 15000;
        dy1 = $signed($urandom_range(30000, 0)) - 15000;
        it.first_start_x  = COORD_W'(cx - dx0 / 2);
        it.first_start_y  = COORD_W'(cy - dy0 / 2);
        it.first_end_x    = COORD_W'(cx + dx0 / 2);
        it.first_end_y    = COORD_W'(cy + dy0 / 2);
        it.second_start_x = COORD_W'(cx - dx1 / 3);
        it.second_start_y = COORD_W'(cy - dy1 / 3);
        it.second_end_x   = COORD_W'(cx + dx1 / 2);
        it.second_end_y   = COORD_W'(cy + dy1 / 2);
        return it;
    endfunction

    function automatic t_seg_item mk(int ax, int ay, int bx, int by,
                                     int px, int py, int qx, int qy);
        t_seg_item it;
        it = {COORD_W'(ax), COORD_W'(ay), COORD_W'(bx), COORD_W'(by),
              COORD_W'(px), COORD_W'(py), COORD_W'(qx), COORD_W'(qy)};
        return it;
    endfunction

    // Directed: plain crossing, touching, collinear, degenerate, extremes
    task automatic test_directed();
        idle_pct = 0;
        send_pair(mk(-160, -160, 160, 160, -160, 160, 160, -160));
        send_pair(mk(0, 0, 100, 0, 50, 0, 50, 80));
        send_pair(mk(0, 0, 100, 0, 100, 0, 100, 80));
        send_pair(mk(0, 0, 100, 0, 20, 0, 200, 0));
        send_pair(mk(0, 0, 100, 0, 120, -5, 130, 5));
        send_pair(mk(30, 30, 30, 30, 0, 0, 60, 60));
        send_pair(mk(0, -10, 0, 10, 5, 5, 5, 5));
        send_pair(mk(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
        send_pair(mk(-32768, 0, 32767, 0, 1, -32768, 0, 32767));
        send_pair(mk(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32767));
        send_pair(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_pair(mk(-32768, -32768, -32768, -32768, -1, -1, -1, -1));
        send_pair(mk(1, 3, 7, -5, -3, -2, 9, 4));
        send_pair(mk(-7, 1, 3, 1, -1, -9, 2, 5));
        drain();
    endtask

    // Random phase at a given sender idle rate
    task automatic test_random(int pct, int count);
        idle_pct = pct;
        repeat (count) begin
            if ($urandom_range(3, 0) != 0) send_pair(crossing_pair());
            else send_pair(rand_pair());
        end
        idle_pct = 0;
    endtask

    // Sender pauses until the pipeline is empty, then resumes
    task automatic test_pause();
        test_random(0, 30);
        drain();
        test_random(0, 30);
        drain();
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_cross_item exp_r;
        if (i_rst_n && o_strobe) begin
            if (crossings_due.size() == 0) begin
                $display("%0t: unexpected result %p", $time, o_result);
                failed = 1'b1;
            end else begin
                exp_r = crossings_due.pop_front();
                if (o_result.crossing !== exp_r.crossing) begin
                    $display("%0t: crossing exp %0b got %0b", $time,
                             exp_r.crossing, o_result.crossing);
                    failed = 1'b1;
                end
                if (o_result.cross_x !== exp_r.cross_x) begin
                    $display("%0t: cross_x exp %0d got %0d", $time,
                             $signed(exp_r.cross_x), $signed(o_result.cross_x));
                    failed = 1'b1;
                end
                if (o_result.cross_y !== exp_r.cross_y) begin
                    $display("%0t: cross_y exp %0d got %0d", $time,
                             $signed(exp_r.cross_y), $signed(o_result.cross_y));
                    failed = 1'b1;
                end
            end
        end
    end

    // Timeout
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > MAX_CYCLE) begin
            $display("tb_segment_intersection_point_unit NOT OK");
            $finish;
        end
    end

    initial begin
        failed    = 1'b0;
        cycle_cnt = 0;
        idle_pct  = 0;
        i_rst_n   = 1'b0;
        i_start   = 1'b0;
        i_item    = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(0, 170);
        test_random(57, 170);
        test_random(37, 170);
        test_random(0, 130);
        test_pause();
        drain();

        if (!failed && crossings_due.size() == 0) begin
            $display("tb_segment_intersection_point_unit OK");
        end else begin
            $display("tb_segment_intersection_point_unit NOT OK");
        end
        $finish;
    end
endmodule

// ===== segment_intersection_point_unit.f =====
design/sipu_pkg.sv
design/sipu_div_cell.sv
design/segment_intersection_point_unit.sv
verif/tb_segment_intersection_point_unit.sv
